[src/sndc_pkg.sv]
// ----------------------------------------------------------------------------
// sndc_pkg
// shared constants, codes and types of the strided copy address generator
// ----------------------------------------------------------------------------
`default_nettype none

package sndc_pkg;

	// geometry
	localparam int MAX_RANK = 8;
	localparam int AXIS_W   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam int RANK_W   = $clog2(MAX_RANK + 1);
	localparam int ADDR_W   = 48;
	localparam int EXT_W    = 32;
	localparam int STEP_W   = 32;
	localparam int EB_W     = 16;

	// input item kinds
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_NEXT  = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_RANK       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ELEM_BYTES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_BASE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_BASE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_OFFSET = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DST_OFFSET = 3'd5;

	// request to the shared multiplier
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] a;
		logic [EB_W-1:0]   b;
	} mul_req_t;

	// sign extension of a stride in elements to address width
	function automatic logic [ADDR_W-1:0] sext_step(input logic [STEP_W-1:0] s);
		sext_step = {{(ADDR_W-STEP_W){s[STEP_W-1]}}, s};
	endfunction

endpackage

`default_nettype wire

[src/sndc_mul.sv]
// ----------------------------------------------------------------------------
// sndc_mul
// shared registered multiplier, address width by 16 bits, low product bits kept
// ----------------------------------------------------------------------------
`default_nettype none

module sndc_mul
	import sndc_pkg::*;
(
	input  wire logic              clk,
	input  wire mul_req_t          req,
	output logic      [ADDR_W-1:0] p
);

	logic [ADDR_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			p_q <= req.a * ADDR_W'(req.b);
		end
	end

	assign p = p_q;

endmodule

`default_nettype wire

[src/strided_nd_copy_address_generator_top.sv]
// ----------------------------------------------------------------------------
// strided_nd_copy_address_generator_top
// address engine for an n-dimensional strided copy of rank 0 to MAX_RANK
// ----------------------------------------------------------------------------
// The block works on one input transfer at a time and drops s_tready while it
// is busy. A load transfer is dropped while a copy is active; otherwise the
// stride for each side is formed by one pass through the shared 48x16
// multiplier, and the per-axis rewind amount (extent - 1) * stride by three
// more passes, one 16-bit stride slice each, for source and then destination.
// A next transfer makes two multiplier passes for the start offsets times the
// element size, then visits each axis the carry ripples through (none for a
// rank zero copy, else 1 to MAX_RANK), then hands the result to the output
// register; a next transfer while no copy is active goes straight to the
// output register hand-off. The result waits in an output register, so the
// next input transfer is taken while the previous result stalls.
// Configuration writes are always accepted and take effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module strided_nd_copy_address_generator_top
	import sndc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input stream
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic         [103:0] s_tdata,  // axis, extent, src_step, dst_step, zero pad
	input  wire logic           [1:0] s_tuser,  // op
	// result stream
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic               [95:0] m_tdata,  // src_addr, dst_addr
	output logic                      m_tlast,  // last element of the copy
	output logic                [0:0] m_tuser,  // none_left
	// configuration write channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic    [ADDR_W-1:0] cfg_data
);

	// sequencer states
	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_LD_MUL  = 4'd1;  // stride = step * elem_bytes
	localparam logic [3:0] ST_LD_STR  = 4'd2;  // store stride, first rewind slice
	localparam logic [3:0] ST_LD_WRAP = 4'd3;  // accumulate rewind slices
	localparam logic [3:0] ST_N_MS    = 4'd4;  // src offset * elem_bytes
	localparam logic [3:0] ST_N_AS    = 4'd5;  // src address sum, dst multiply
	localparam logic [3:0] ST_N_AD    = 4'd6;  // dst address sum
	localparam logic [3:0] ST_ADV     = 4'd7;  // one axis per cycle
	localparam logic [3:0] ST_RESULT  = 4'd8;  // hand off to output register

	// input field unpacking
	logic  [2:0]        in_axis;
	logic [EXT_W-1:0]   in_extent;
	logic [STEP_W-1:0]  in_src_step;
	logic [STEP_W-1:0]  in_dst_step;

	assign in_axis     = s_tdata[2:0];
	assign in_extent   = s_tdata[34:3];
	assign in_src_step = s_tdata[66:35];
	assign in_dst_step = s_tdata[98:67];

	// configuration registers
	logic [3:0]         rank_q;
	logic [EB_W-1:0]    eb_q;
	logic [ADDR_W-1:0]  src_base_q;
	logic [ADDR_W-1:0]  dst_base_q;
	logic [EXT_W-1:0]   src_off_q;
	logic [EXT_W-1:0]   dst_off_q;

	// axis tables and copy state
	logic [EXT_W-1:0]   ext_tab_q [MAX_RANK];
	logic [ADDR_W-1:0]  ss_tab_q  [MAX_RANK];  // source byte stride
	logic [ADDR_W-1:0]  ds_tab_q  [MAX_RANK];  // destination byte stride
	logic [ADDR_W-1:0]  sw_tab_q  [MAX_RANK];  // source rewind, (extent-1)*stride
	logic [ADDR_W-1:0]  dw_tab_q  [MAX_RANK];  // destination rewind
	logic [EXT_W-1:0]   odo_q     [MAX_RANK];
	logic [ADDR_W-1:0]  ro_q;
	logic [ADDR_W-1:0]  wo_q;
	logic               active_q;

	// sequencer
	logic [3:0]         state_q;
	logic               side_q;     // 0 source, 1 destination
	logic [1:0]         pchunk_q;   // stride slice now in the product register
	logic [AXIS_W-1:0]  ax_q;
	logic [EXT_W-1:0]   ext_q;
	logic [STEP_W-1:0]  src_step_q;
	logic [STEP_W-1:0]  dst_step_q;
	logic [ADDR_W-1:0]  stride_q;
	logic [ADDR_W-1:0]  acc_q;

	// staged result and output register
	logic [ADDR_W-1:0]  sa_q;
	logic [ADDR_W-1:0]  da_q;
	logic               last_q;
	logic               none_q;
	logic               out_valid_q;
	logic [ADDR_W-1:0]  out_src_q;
	logic [ADDR_W-1:0]  out_dst_q;
	logic               out_last_q;
	logic               out_none_q;

	// shared multiplier
	mul_req_t           mul_req;
	logic [ADDR_W-1:0]  prod;

	sndc_mul u_mul (
		.clk (clk),
		.req (mul_req),
		.p   (prod)
	);

	// combinational helpers
	logic [RANK_W-1:0]  used_rank;
	logic               copy_empty;
	logic [ADDR_W-1:0]  ext_m1;
	logic [ADDR_W-1:0]  wrap_sum;
	logic [EXT_W-1:0]   odo_inc;
	logic               odo_hit;
	logic               in_xfer;
	logic               load_ok;
	logic               out_load;

	assign used_rank = (int'(rank_q) > MAX_RANK) ? RANK_W'(MAX_RANK) : RANK_W'(rank_q);
	assign ext_m1    = ADDR_W'(ext_q) - ADDR_W'(1);
	assign odo_inc   = odo_q[ax_q] + EXT_W'(1);
	assign odo_hit   = (odo_inc == ext_tab_q[ax_q]);
	assign in_xfer   = s_tvalid && s_tready;
	assign load_ok   = !active_q && (int'(in_axis) < MAX_RANK);
	// staged result moves into a free or draining output register
	assign out_load  = (state_q == ST_RESULT) && (!out_valid_q || m_tready);

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// copy is empty if any axis in use has zero extent
	always_comb begin
		copy_empty = 1'b0;
		for (int a = 0; a < MAX_RANK; a++) begin
			if ((a < int'(used_rank)) && (ext_tab_q[a] == '0)) begin
				copy_empty = 1'b1;
			end
		end
	end

	// partial product aligned to its stride slice
	always_comb begin
		case (pchunk_q)
			2'd0:    wrap_sum = acc_q + prod;
			2'd1:    wrap_sum = acc_q + (prod << 16);
			2'd2:    wrap_sum = acc_q + (prod << 32);
			default: wrap_sum = acc_q;
		endcase
	end

	// operand selection for the shared multiplier
	always_comb begin
		mul_req = '0;
		case (state_q)
			ST_LD_MUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = sext_step(side_q ? dst_step_q : src_step_q);
				mul_req.b  = eb_q;
			end
			ST_LD_STR: begin
				mul_req.en = 1'b1;
				mul_req.a  = ext_m1;
				mul_req.b  = prod[15:0];
			end
			ST_LD_WRAP: begin
				mul_req.en = (pchunk_q != 2'd2);
				mul_req.a  = ext_m1;
				mul_req.b  = (pchunk_q == 2'd0) ? stride_q[31:16] : stride_q[47:32];
			end
			ST_N_MS: begin
				mul_req.en = 1'b1;
				mul_req.a  = ADDR_W'(src_off_q);
				mul_req.b  = eb_q;
			end
			ST_N_AS: begin
				mul_req.en = 1'b1;
				mul_req.a  = ADDR_W'(dst_off_q);
				mul_req.b  = eb_q;
			end
			default: mul_req = '0;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q     <= '0;
			eb_q       <= EB_W'(1);
			src_base_q <= '0;
			dst_base_q <= '0;
			src_off_q  <= '0;
			dst_off_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RANK:       rank_q     <= cfg_data[3:0];
				REG_ELEM_BYTES: eb_q       <= cfg_data[EB_W-1:0];
				REG_SRC_BASE:   src_base_q <= cfg_data;
				REG_DST_BASE:   dst_base_q <= cfg_data;
				REG_SRC_OFFSET: src_off_q  <= cfg_data[EXT_W-1:0];
				REG_DST_OFFSET: dst_off_q  <= cfg_data[EXT_W-1:0];
				default: ;
			endcase
		end
	end

	// stride and rewind tables, zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < MAX_RANK; a++) begin
				ss_tab_q[a] <= '0;
				ds_tab_q[a] <= '0;
				sw_tab_q[a] <= '0;
				dw_tab_q[a] <= '0;
			end
		end else begin
			if (state_q == ST_LD_STR) begin
				if (side_q) begin
					ds_tab_q[ax_q] <= prod;
				end else begin
					ss_tab_q[ax_q] <= prod;
				end
			end
			if ((state_q == ST_LD_WRAP) && (pchunk_q == 2'd2)) begin
				if (side_q) begin
					dw_tab_q[ax_q] <= wrap_sum;
				end else begin
					sw_tab_q[ax_q] <= wrap_sum;
				end
			end
		end
	end

	// sequencer and copy state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= 1'b0;
			ro_q        <= '0;
			wo_q        <= '0;
			side_q      <= 1'b0;
			pchunk_q    <= '0;
			ax_q        <= '0;
			ext_q       <= '0;
			src_step_q  <= '0;
			dst_step_q  <= '0;
			stride_q    <= '0;
			acc_q       <= '0;
			sa_q        <= '0;
			da_q        <= '0;
			last_q      <= 1'b0;
			none_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_src_q   <= '0;
			out_dst_q   <= '0;
			out_last_q  <= 1'b0;
			out_none_q  <= 1'b0;
			for (int a = 0; a < MAX_RANK; a++) begin
				ext_tab_q[a] <= '0;
				odo_q[a]     <= '0;
			end
		end else begin
			// output register fills from the sequencer, drains independently
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_src_q   <= sa_q;
				out_dst_q   <= da_q;
				out_last_q  <= last_q;
				out_none_q  <= none_q;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						case (s_tuser)
							OP_LOAD: begin
								if (load_ok) begin
									ext_tab_q[AXIS_W'(in_axis)] <= in_extent;
									ax_q       <= AXIS_W'(in_axis);
									ext_q      <= in_extent;
									src_step_q <= in_src_step;
									dst_step_q <= in_dst_step;
									side_q     <= 1'b0;
									state_q    <= ST_LD_MUL;
								end
							end
							OP_START: begin
								for (int a = 0; a < MAX_RANK; a++) begin
									odo_q[a] <= '0;
								end
								ro_q     <= '0;
								wo_q     <= '0;
								active_q <= !copy_empty;
							end
							OP_NEXT: begin
								if (active_q) begin
									none_q  <= 1'b0;
									state_q <= ST_N_MS;
								end else begin
									// idle copy: flagged result with zero fields
									sa_q    <= '0;
									da_q    <= '0;
									last_q  <= 1'b0;
									none_q  <= 1'b1;
									state_q <= ST_RESULT;
								end
							end
							default: ;
						endcase
					end
				end
				ST_LD_MUL: begin
					state_q <= ST_LD_STR;
				end
				ST_LD_STR: begin
					stride_q <= prod;
					acc_q    <= '0;
					pchunk_q <= 2'd0;
					state_q  <= ST_LD_WRAP;
				end
				ST_LD_WRAP: begin
					if (pchunk_q == 2'd2) begin
						if (side_q) begin
							state_q <= ST_IDLE;
						end else begin
							side_q  <= 1'b1;
							state_q <= ST_LD_MUL;
						end
					end else begin
						acc_q    <= wrap_sum;
						pchunk_q <= pchunk_q + 2'd1;
					end
				end
				ST_N_MS: begin
					state_q <= ST_N_AS;
				end
				ST_N_AS: begin
					sa_q    <= src_base_q + prod + ro_q;
					state_q <= ST_N_AD;
				end
				ST_N_AD: begin
					da_q <= dst_base_q + prod + wo_q;
					if (used_rank == '0) begin
						// rank zero copy has a single element
						active_q <= 1'b0;
						last_q   <= 1'b1;
						state_q  <= ST_RESULT;
					end else begin
						ax_q    <= AXIS_W'(used_rank - RANK_W'(1));
						state_q <= ST_ADV;
					end
				end
				ST_ADV: begin
					if (odo_hit && (ax_q != '0)) begin
						// wrap this axis back and carry outward
						odo_q[ax_q] <= '0;
						ro_q        <= ro_q - sw_tab_q[ax_q];
						wo_q        <= wo_q - dw_tab_q[ax_q];
						ax_q        <= ax_q - AXIS_W'(1);
					end else begin
						odo_q[ax_q] <= odo_inc;
						ro_q        <= ro_q + ss_tab_q[ax_q];
						wo_q        <= wo_q + ds_tab_q[ax_q];
						last_q      <= odo_hit;
						if (odo_hit) begin
							active_q <= 1'b0;
						end
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {out_dst_q, out_src_q};
	assign m_tlast    = out_last_q;
	assign m_tuser[0] = out_none_q;

	// the carry walk never visits an axis beyond the rank in use
	a_adv_axis_in_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV) |-> (int'(ax_q) < int'(used_rank)))
		else $error("carry walk outside the active rank");

	// a none_left result carries zero addresses and no last mark
	a_none_left_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> ((m_tdata == '0) && !m_tlast))
		else $error("none_left result with nonzero fields");

	// rewind accumulation covers exactly three stride slices
	a_wrap_slice: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LD_WRAP) |-> (pchunk_q != 2'd3))
		else $error("rewind slice index out of range");

	// a new result never overwrites one that is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> out_valid_q)
		else $error("stalled result dropped");

endmodule

`default_nettype wire

[tb/sv/strided_nd_copy_address_generator_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// strided_nd_copy_address_generator_top_tb
// self-checking bench for the strided copy address engine: a directed table
// walks reset state, rank zero, stride and base extremes, finished and idle
// copies, restarts and locked loads; random phases then rewrite the registers
// and run well-formed copies mixed with noise, under random stalls on both
// streams, while a predictor in the bench builds the expected addresses
// ----------------------------------------------------------------------------

module strided_nd_copy_address_generator_top_tb;
	import sndc_pkg::*;

	// bench constants
	localparam logic [1:0]           OP_NONE        = 2'd3;  // ignored by the block
	localparam logic [CFG_IDX_W-1:0] REG_SPARE      = 3'd7;  // no register behind it
	localparam int                   IDLE_MAX       = 12;
	localparam int                   HOLD_CYCLES    = 200;
	localparam int                   SETTLE_CYCLES  = 30;    // covers a load in flight
	localparam int                   WATCHDOG_LIMIT = 3000;
	localparam int                   ITEM_TARGET    = 2000;
	localparam int                   PHASE_ITEMS    = 250;
	localparam int                   MAX_ELEMS      = 48;    // cap on elements per copy
	localparam int                   MAX_REPORTS    = 200;

	// one address result as it leaves the block
	typedef struct packed {
		logic [ADDR_W-1:0] src_addr;
		logic [ADDR_W-1:0] dst_addr;
		logic              last;
		logic              none_left;
	} addr_res_t;

	localparam addr_res_t NOTHING_LEFT = '{src_addr: '0, dst_addr: '0, last: 1'b0, none_left: 1'b1};

	// one row of the directed table: an input transfer or a register write
	typedef struct packed {
		logic                 is_reg;
		logic [1:0]           op;
		logic [2:0]           axis;
		logic [EXT_W-1:0]     extent;
		logic [STEP_W-1:0]    src_step;
		logic [STEP_W-1:0]    dst_step;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [ADDR_W-1:0]    reg_val;
		logic                 pinned;    // expected result typed in below
		addr_res_t            want;
	} stim_row_t;

	// ports
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [103:0]         s_tdata;   // axis, extent, src_step, dst_step, zero pad
	logic [1:0]           s_tuser;   // op
	logic                 m_tvalid;
	logic                 m_tready;
	logic [95:0]          m_tdata;   // src_addr, dst_addr
	logic                 m_tlast;   // last element of the copy
	logic [0:0]           m_tuser;   // none_left
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;

	// register copy held by the predictor
	logic [3:0]           cur_rank;
	logic [EB_W-1:0]      cur_elem_bytes;
	logic [ADDR_W-1:0]    cur_src_base;
	logic [ADDR_W-1:0]    cur_dst_base;
	logic [EXT_W-1:0]     cur_src_skip;
	logic [EXT_W-1:0]     cur_dst_skip;

	// shape tables and odometer of the predictor
	logic [EXT_W-1:0]     extent_tab     [MAX_RANK];
	logic [ADDR_W-1:0]    src_stride_tab [MAX_RANK];
	logic [ADDR_W-1:0]    dst_stride_tab [MAX_RANK];
	logic [EXT_W-1:0]     odometer       [MAX_RANK];
	logic [ADDR_W-1:0]    src_walk;
	logic [ADDR_W-1:0]    dst_walk;
	bit                   copy_active;

	// addresses still owed by the block, oldest first
	addr_res_t            pending_addrs[$];
	addr_res_t            head_addr;
	stim_row_t            dir_tab[$];

	// run control shared between the sender, the receiver and the checks
	bit                   tx_idle;
	bit                   rx_idle;
	bit                   hold_rx = 1'b0;
	int                   items_sent = 0;
	int                   mismatches = 0;
	int                   reports = 0;
	int                   quiet_cycles = 0;
	int                   rank_pick[10] = '{8, 0, 15, 1, 3, 5, 2, 7, 4, 6};

	strided_nd_copy_address_generator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// ranks above the table depth use the whole table
	function automatic int axes_in_use();
		return (cur_rank > 4'(MAX_RANK)) ? MAX_RANK : int'(cur_rank);
	endfunction

	// bump the innermost axis, rewind and carry outward, stop after the last element
	function automatic void step_odometer();
		int a;
		a = axes_in_use() - 1;
		if (a < 0) begin
			copy_active = 1'b0;
			return;
		end
		while (a >= 0) begin
			odometer[a] = odometer[a] + 32'd1;
			src_walk    = src_walk + src_stride_tab[a];
			dst_walk    = dst_walk + dst_stride_tab[a];
			if (odometer[a] != extent_tab[a])
				return;
			if (a == 0) begin
				copy_active = 1'b0;
				return;
			end
			odometer[a] = '0;
			// back to the start of this axis
			src_walk = src_walk - {16'd0, extent_tab[a]} * src_stride_tab[a];
			dst_walk = dst_walk - {16'd0, extent_tab[a]} * dst_stride_tab[a];
			a--;
		end
	endfunction

	// update the model for one accepted input transfer, queue what it owes
	function automatic void predict_item(input logic [1:0] op, input logic [2:0] axis,
		input logic [EXT_W-1:0] extent, input logic [STEP_W-1:0] src_step,
		input logic [STEP_W-1:0] dst_step, input bit pinned, input addr_res_t want);
		addr_res_t got;
		bit        emits;
		int        a;
		emits = 1'b0;
		got   = NOTHING_LEFT;
		case (op)
			OP_LOAD: begin
				// the shape is locked while a copy runs
				if (!copy_active) begin
					extent_tab[axis]     = extent;
					src_stride_tab[axis] = {{16{src_step[31]}}, src_step} * {32'd0, cur_elem_bytes};
					dst_stride_tab[axis] = {{16{dst_step[31]}}, dst_step} * {32'd0, cur_elem_bytes};
				end
			end
			OP_START: begin
				for (a = 0; a < MAX_RANK; a++)
					odometer[a] = '0;
				src_walk    = '0;
				dst_walk    = '0;
				copy_active = 1'b1;
				// any zero extent in use makes the copy empty
				for (a = 0; a < axes_in_use(); a++)
					if (extent_tab[a] == '0)
						copy_active = 1'b0;
			end
			OP_NEXT: begin
				emits = 1'b1;
				if (copy_active) begin
					got.src_addr  = cur_src_base + {16'd0, cur_src_skip} * {32'd0, cur_elem_bytes}
						+ src_walk;
					got.dst_addr  = cur_dst_base + {16'd0, cur_dst_skip} * {32'd0, cur_elem_bytes}
						+ dst_walk;
					step_odometer();
					got.last      = !copy_active;
					got.none_left = 1'b0;
				end
			end
			default: ;
		endcase
		if (emits)
			pending_addrs.push_back(pinned ? want : got);
	endfunction

	function automatic void predict_reg_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [ADDR_W-1:0] val);
		case (idx)
			REG_RANK:       cur_rank       = val[3:0];
			REG_ELEM_BYTES: cur_elem_bytes = val[EB_W-1:0];
			REG_SRC_BASE:   cur_src_base   = val;
			REG_DST_BASE:   cur_dst_base   = val;
			REG_SRC_OFFSET: cur_src_skip   = val[EXT_W-1:0];
			REG_DST_OFFSET: cur_dst_skip   = val[EXT_W-1:0];
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	function automatic stim_row_t item_row(input logic [1:0] op, input logic [2:0] axis,
		input logic [EXT_W-1:0] extent, input logic [STEP_W-1:0] src_step,
		input logic [STEP_W-1:0] dst_step);
		stim_row_t row;
		row          = '0;
		row.op       = op;
		row.axis     = axis;
		row.extent   = extent;
		row.src_step = src_step;
		row.dst_step = dst_step;
		return row;
	endfunction

	function automatic stim_row_t pinned_row(input logic [1:0] op, input addr_res_t want);
		stim_row_t row;
		row        = item_row(op, 3'd0, '0, '0, '0);
		row.pinned = 1'b1;
		row.want   = want;
		return row;
	endfunction

	function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
		input logic [ADDR_W-1:0] val);
		stim_row_t row;
		row         = '0;
		row.is_reg  = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	// strides: small signed, fully random, or the 32-bit corners
	function automatic logic [STEP_W-1:0] rand_step();
		case ($urandom_range(0, 2))
			0: return 32'(int'($urandom_range(0, 8)) - 4);
			1: return $urandom;
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_FFFF;
					default: return 32'd1;
				endcase
			end
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] pick_addr(input int sel);
		case (sel % 3)
			0: return '0;
			1: return '1;
			default: return {16'($urandom), $urandom};
		endcase
	endfunction

	// element offsets, with junk above bit 31 now and then
	function automatic logic [ADDR_W-1:0] pick_skip(input int sel);
		case (sel % 3)
			0: return '0;
			1: return 48'hFFFF_FFFF;
			default: return {16'($urandom), $urandom};
		endcase
	endfunction

	// offer one input transfer after a random gap, predict it once taken
	task automatic send_item(input logic [1:0] op, input logic [2:0] axis,
		input logic [EXT_W-1:0] extent, input logic [STEP_W-1:0] src_step,
		input logic [STEP_W-1:0] dst_step, input bit pinned, input addr_res_t want);
		int gap;
		gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {5'd0, dst_step, src_step, extent, axis};
		s_tuser  <= op;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		predict_item(op, axis, extent, src_step, dst_step, pinned, want);
		if (op != OP_NONE)
			items_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		predict_reg_write(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending, collect every owed result, then let a load finish inside
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_addrs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_next();
		send_item(OP_NEXT, 3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, 1'b0, '0);
	endtask

	// one random sequence: mostly a whole copy, sometimes a cut one or noise
	task automatic run_copy();
		int         axes;
		int         n_elems;
		int         n_next;
		int         a;
		int         k;
		logic [31:0] ext;
		logic [3:0]  saved_rank;
		if ($urandom_range(0, 99) < 15) begin
			send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), $urandom, $urandom,
				$urandom, 1'b0, '0);
			return;
		end
		// a running copy locks the tables, so walk it out first
		for (k = 0; k < 60 && copy_active; k++)
			send_next();
		// a huge extent from noise never ends: run one rank zero copy to clear it
		if (copy_active) begin
			saved_rank = cur_rank;
			settle();
			write_reg(REG_RANK, '0);
			send_item(OP_START, 3'd0, '0, '0, '0, 1'b0, '0);
			send_next();
			settle();
			write_reg(REG_RANK, {44'd0, saved_rank});
		end
		axes    = axes_in_use();
		n_elems = 1;
		for (a = 0; a < axes; a++) begin
			if ($urandom_range(0, 99) < 3) begin
				ext = '0;
			end else begin
				ext = $urandom_range(1, 3);
				if (n_elems * int'(ext) > MAX_ELEMS)
					ext = 32'd1;
			end
			n_elems = n_elems * int'(ext);
			send_item(OP_LOAD, 3'(a), ext, rand_step(), rand_step(), 1'b0, '0);
		end
		// an axis above the rank may take any shape
		if (axes < MAX_RANK && $urandom_range(0, 9) == 0)
			send_item(OP_LOAD, 3'($urandom_range(axes, MAX_RANK - 1)), $urandom, $urandom,
				$urandom, 1'b0, '0);
		send_item(OP_START, 3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, 1'b0, '0);
		n_next = n_elems + $urandom_range(0, 2);
		if ($urandom_range(0, 9) == 0)
			n_next = $urandom_range(0, n_elems);
		repeat (n_next) send_next();
	endtask

	// ------------------------------------------------------------------------
	// sender: directed table, then random phases
	// ------------------------------------------------------------------------
	initial begin
		int          phase;
		int          phase_start;
		int          a;
		logic [47:0] val;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		tx_idle   = 1'b1;
		rx_idle   = 1'b1;

		// predictor at reset
		cur_rank       = '0;
		cur_elem_bytes = 16'd1;
		cur_src_base   = '0;
		cur_dst_base   = '0;
		cur_src_skip   = '0;
		cur_dst_skip   = '0;
		for (a = 0; a < MAX_RANK; a++) begin
			extent_tab[a]     = '0;
			src_stride_tab[a] = '0;
			dst_stride_tab[a] = '0;
			odometer[a]       = '0;
		end
		src_walk    = '0;
		dst_walk    = '0;
		copy_active = 1'b0;

		// next while idle, then the single element of a rank zero copy
		dir_tab.push_back(pinned_row(OP_NEXT, NOTHING_LEFT));
		dir_tab.push_back(item_row(OP_START, 3'd0, '0, '0, '0));
		dir_tab.push_back(pinned_row(OP_NEXT,
			'{src_addr: '0, dst_addr: '0, last: 1'b1, none_left: 1'b0}));
		dir_tab.push_back(pinned_row(OP_NEXT, NOTHING_LEFT));
		// unused op with every field bit set
		dir_tab.push_back(item_row(OP_NONE, 3'd7, '1, '1, '1));
		// top of the address space plus the largest offset wraps around
		dir_tab.push_back(reg_row(REG_SRC_BASE, '1));
		dir_tab.push_back(reg_row(REG_SRC_OFFSET, 48'hFFFF_FFFF));
		dir_tab.push_back(reg_row(REG_DST_BASE, 48'h8000_0000_0001));
		dir_tab.push_back(item_row(OP_START, 3'd0, '0, '0, '0));
		dir_tab.push_back(item_row(OP_NEXT, 3'd0, '0, '0, '0));
		// 2 x 2 copy with the stride corners, an axis above the rank ignored
		dir_tab.push_back(reg_row(REG_RANK, 48'd2));
		dir_tab.push_back(item_row(OP_LOAD, 3'd0, 32'd2, 32'h7FFF_FFFF, 32'h8000_0000));
		dir_tab.push_back(item_row(OP_LOAD, 3'd1, 32'd2, 32'hFFFF_FFFF, 32'd1));
		dir_tab.push_back(item_row(OP_LOAD, 3'd7, '1, 32'h8000_0000, 32'h7FFF_FFFF));
		dir_tab.push_back(item_row(OP_START, 3'd0, '0, '0, '0));
		repeat (4) dir_tab.push_back(item_row(OP_NEXT, 3'd0, '0, '0, '0));
		dir_tab.push_back(pinned_row(OP_NEXT, NOTHING_LEFT));
		// load refused mid-copy, restart from the first element
		dir_tab.push_back(item_row(OP_START, 3'd0, '0, '0, '0));
		dir_tab.push_back(item_row(OP_NEXT, 3'd0, '0, '0, '0));
		dir_tab.push_back(item_row(OP_LOAD, 3'd0, '0, 32'd3, 32'd3));
		dir_tab.push_back(item_row(OP_START, 3'd0, '0, '0, '0));
		dir_tab.push_back(item_row(OP_NEXT, 3'd0, '0, '0, '0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_reg) begin
				settle();
				write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
			end else begin
				send_item(dir_tab[i].op, dir_tab[i].axis, dir_tab[i].extent,
					dir_tab[i].src_step, dir_tab[i].dst_step, dir_tab[i].pinned, dir_tab[i].want);
			end
		end

		// random phases, each with a fresh register setting
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			settle();
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			write_reg(REG_RANK, 48'(rank_pick[phase % 10]));
			case (phase % 4)
				0: val = 48'd1;
				1: val = 48'hFFFF;
				2: val = (phase == 2) ? 48'd0 : 48'($urandom_range(1, 65535));
				default: val = {16'($urandom), 16'($urandom), 16'($urandom_range(2, 16))};
			endcase
			write_reg(REG_ELEM_BYTES, val);
			write_reg(REG_SRC_BASE, pick_addr(phase));
			write_reg(REG_DST_BASE, pick_addr(phase + 1));
			write_reg(REG_SRC_OFFSET, pick_skip(phase + 2));
			write_reg(REG_DST_OFFSET, pick_skip(phase));
			if (phase == 1)
				write_reg(REG_SPARE, {16'($urandom), $urandom});
			// receiver holds off while results pile up and the input backs up
			if (phase == 2) begin
				hold_rx = 1'b1;
				repeat (30) send_next();
			end
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS)
				run_copy();
			phase++;
		end

		settle();
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// receiver: random ready gaps per transfer, one long hold on request
	// ------------------------------------------------------------------------
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		m_tready <= 1'b1;
		forever begin
			do @(posedge clk); while (!(m_tvalid && m_tready) && !hold_rx);
			if (hold_rx) begin
				hold_rx = 1'b0;
				gap     = HOLD_CYCLES;
			end else begin
				gap = rx_idle ? $urandom_range(0, IDLE_MAX) : 0;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// result check against the oldest owed address
	// ------------------------------------------------------------------------
	function automatic void check_field(input string field, input logic [ADDR_W-1:0] want,
		input logic [ADDR_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (reports < MAX_REPORTS)
				$display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
			reports++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_addrs.size() == 0) begin
				mismatches++;
				if (reports < MAX_REPORTS)
					$display("%0t ns: result with none expected, expected nothing, got %h %b %b",
						$time, m_tdata, m_tlast, m_tuser);
				reports++;
			end else begin
				head_addr = pending_addrs.pop_front();
				check_field("src_addr", head_addr.src_addr, m_tdata[47:0]);
				check_field("dst_addr", head_addr.dst_addr, m_tdata[95:48]);
				check_field("last", 48'(head_addr.last), 48'(m_tlast));
				check_field("none_left", 48'(head_addr.none_left), 48'(m_tuser[0]));
			end
		end
	end

	// watchdog: too long without any transfer on any channel
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
			|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles < WATCHDOG_LIMIT) begin
			quiet_cycles <= quiet_cycles + 1;
		end else begin
			$display("Verification failed");
			$finish;
		end
	end

endmodule

[files.f]
src/sndc_pkg.sv
src/sndc_mul.sv
src/strided_nd_copy_address_generator_top.sv
tb/sv/strided_nd_copy_address_generator_top_tb.sv
